// ===== sv/esd_pkg.sv =====
`default_nettype none

package esd_pkg;

  localparam int unsigned ValueW = 10;
  localparam int unsigned CountW = 2;

  // Decoder state, one-hot.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_ESC  = 3'b010,
    MODE_NUM  = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    BASE_HEX = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2
  } base_e;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] Ch1      = 8'h31;
  localparam logic [7:0] Ch7      = 8'h37;
  localparam logic [7:0] Ch9      = 8'h39;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoF    = 8'h66;

  localparam logic [7:0] CodeNl  = 8'd10;
  localparam logic [7:0] CodeCr  = 8'd13;
  localparam logic [7:0] CodeTab = 8'd9;
  localparam logic [7:0] CodeBs  = 8'd8;

  localparam logic [CountW-1:0] HexLimit = 2'd2;
  localparam logic [CountW-1:0] NumLimit = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } result_t;

  // Results produced by one request: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    r1;
    result_t    r0;
  } emit_t;

endpackage

`default_nettype wire

// ===== sv/esd_decode.sv =====
`default_nettype none

module esd_decode
  import esd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_in_i,
  output emit_t           emit_o
);

  mode_e              mode_q, mode_d;
  base_e              base_q, base_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [ValueW-1:0]  value_q, value_d;

  logic [7:0]         c;
  logic [3:0]         dval;
  logic               is_char;
  logic               dig_ok;
  logic [ValueW-1:0]  scaled;
  logic [ValueW-1:0]  acc;
  logic [CountW-1:0]  limit;
  logic [CountW-1:0]  count_inc;
  result_t            res [2];
  logic [1:0]         n;

  assign c = in_byte_i;

  // Digit value of the byte and whether it is a digit in the open base.
  always_comb begin
    is_char = 1'b1;
    dval    = 4'd0;
    if (c >= Ch0 && c <= Ch9) begin
      dval = c[3:0];
    end else if ((c >= ChUpA && c <= ChUpF) || (c >= ChLoA && c <= ChLoF)) begin
      dval = 4'(c[3:0] + 4'd9);
    end else begin
      is_char = 1'b0;
    end
    case (base_q)
      BASE_HEX: dig_ok = is_char;
      BASE_OCT: dig_ok = is_char && (dval < 4'd8);
      default:  dig_ok = is_char && (dval < 4'd10);
    endcase
  end

  always_comb begin
    case (base_q)
      BASE_HEX: scaled = {value_q[5:0], 4'b0000};
      BASE_OCT: scaled = {value_q[6:0], 3'b000};
      default:  scaled = ValueW'({value_q[6:0], 3'b000} + {value_q[8:0], 1'b0});
    endcase
    acc       = ValueW'(scaled + {6'd0, dval});
    limit     = (base_q == BASE_HEX) ? HexLimit : NumLimit;
    count_inc = CountW'(count_q + 2'd1);
  end

  always_comb begin
    mode_d  = mode_q;
    base_d  = base_q;
    count_d = count_q;
    value_d = value_q;
    n       = 2'd0;
    res[0]  = '0;
    res[1]  = '0;

    case (mode_q)
      MODE_NUM: begin
        if (dig_ok && count_q < limit) begin
          value_d = acc;
          count_d = count_inc;
          if (count_inc >= limit) begin
            res[0] = '{data: acc[7:0], valid: 1'b1, last: 1'b0};
            n      = 2'd1;
            mode_d = MODE_IDLE;
          end
        end else begin
          // Close the number, then treat the byte as fresh input.
          res[0] = '{data: value_q[7:0], valid: 1'b1, last: 1'b0};
          n      = 2'd1;
          mode_d = MODE_IDLE;
          if (c == ChBslash) begin
            mode_d = MODE_ESC;
          end else begin
            res[1] = '{data: c, valid: 1'b1, last: 1'b0};
            n      = 2'd2;
          end
        end
      end
      MODE_ESC: begin
        mode_d = MODE_IDLE;
        n      = 2'd1;
        res[0] = '{data: c, valid: 1'b1, last: 1'b0};
        if (c == ChN) begin
          res[0].data = CodeNl;
        end else if (c == ChR) begin
          res[0].data = CodeCr;
        end else if (c == ChT) begin
          res[0].data = CodeTab;
        end else if (c == ChB) begin
          res[0].data = CodeBs;
        end else if (c == ChX) begin
          n       = 2'd0;
          mode_d  = MODE_NUM;
          base_d  = BASE_HEX;
          count_d = '0;
          value_d = '0;
        end else if (c == Ch0) begin
          n       = 2'd0;
          mode_d  = MODE_NUM;
          base_d  = BASE_OCT;
          count_d = 2'd1;
          value_d = '0;
        end else if (c >= Ch1 && c <= Ch9) begin
          n       = 2'd0;
          mode_d  = MODE_NUM;
          base_d  = BASE_DEC;
          count_d = 2'd1;
          value_d = {6'd0, c[3:0]};
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (c == ChBslash) begin
          mode_d = MODE_ESC;
        end else begin
          res[0] = '{data: c, valid: 1'b1, last: 1'b0};
          n      = 2'd1;
        end
      end
    endcase

    if (last_in_i) begin
      // Flush an open number, give a bare marker if nothing came out.
      if (mode_d == MODE_NUM) begin
        res[n[0]] = '{data: value_d[7:0], valid: 1'b1, last: 1'b0};
        n         = 2'(n + 2'd1);
      end
      if (n == 2'd0) begin
        res[0] = '{data: 8'd0, valid: 1'b0, last: 1'b0};
        n      = 2'd1;
      end
      if (n == 2'd2) begin
        res[1].last = 1'b1;
      end else begin
        res[0].last = 1'b1;
      end
      mode_d  = MODE_IDLE;
      base_d  = BASE_HEX;
      count_d = '0;
      value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      base_q  <= BASE_HEX;
      count_q <= '0;
      value_q <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      base_q  <= base_d;
      count_q <= count_d;
      value_q <= value_d;
    end
  end

  assign emit_o = '{count: n, r1: res[1], r0: res[0]};

endmodule

`default_nettype wire

// ===== sv/escape_sequence_decoder.sv =====
`default_nettype none

// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------------
// in       | in_valid_i / in_ready_o    | in_byte_i[7:0], last_in_i
// out      | out_valid_o / out_ready_i  | out_byte_o[7:0], byte_valid_o, last_out_o
//
// One request is decoded in the cycle it is accepted; its zero, one or two
// results land in a four-entry result queue whose oldest entry shows on the
// output. A new request is taken every cycle while the queue holds at most two
// results, so one byte per cycle is sustained; the single output port sets the
// limit when requests produce two results. Reset returns the decoder to idle
// and empties the queue. Output stalls back up through the queue only.

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            last_out_o
);

  logic       accept;
  logic       pop;
  emit_t      emit;

  // Result queue: registers with read and write pointers.
  result_t    queue_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] fill_q, fill_d;
  logic [1:0] wr_next;
  logic [1:0] push_n;
  result_t    head;

  assign in_ready_o = (fill_q < 3'd3);
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;

  esd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .last_in_i (last_in_i),
    .emit_o    (emit)
  );

  // Push count of this cycle; nothing is pushed without an accepted request.
  assign push_n  = accept ? emit.count : 2'd0;
  assign wr_next = 2'(wr_ptr_q + 2'd1);

  always_comb begin
    wr_ptr_d = 2'(wr_ptr_q + push_n);
    rd_ptr_d = pop ? 2'(rd_ptr_q + 2'd1) : rd_ptr_q;
    fill_d   = 3'(fill_q + {1'b0, push_n} - {2'b00, pop});
  end

  // Store results; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= emit.r0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_next] <= emit.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Present the oldest queued result.
  assign head         = queue_q[rd_ptr_q];
  assign out_valid_o  = (fill_q != 3'd0);
  assign out_byte_o   = head.data;
  assign byte_valid_o = head.valid;
  assign last_out_o   = head.last;

endmodule

`default_nettype wire
